>>> rtl/core/b64d_pkg.sv
// Package for the base64 stream decoder: character table, command and
// result word types, and default queue depths.
// No dependencies; imported by the front end, the back end and the top level.
package b64d_pkg;

   // Slot value of '=' and the code for a character outside the alphabet.
   localparam logic [7:0] PAD_MARK = 8'hFE;
   localparam logic [7:0] NOT_B64  = 8'hFF;

   localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
   localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
   localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CHAR_D0    = 8'h30;
   localparam logic [7:0] CHAR_D9    = 8'h39;

   localparam int CMD_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 2;

   // What follows the bytes of a command.
   typedef enum logic [1:0] {
      TAIL_NONE     = 2'd0, // bytes only, message goes on
      TAIL_EOM_LAST = 2'd1, // the last byte closes the message
      TAIL_EMPTY    = 2'd2, // one extra word: message end without bytes
      TAIL_ERROR    = 2'd3  // one extra word: message end with bad count
   } tail_type;

   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  count;
      tail_type    tail;
   } cmd_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
      logic       format_error;
   } rsp_type;

   // Maps a character to its six-bit value, PAD_MARK for '=' or NOT_B64.
   function automatic logic [7:0] char_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         v = c - CHAR_UC_A;
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         v = c - CHAR_LC_A + 8'd26;
      end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
         v = c - CHAR_D0 + 8'd52;
      end else if (c == CHAR_PLUS) begin
         v = 8'd62;
      end else if (c == CHAR_SLASH) begin
         v = 8'd63;
      end else if (c == CHAR_PAD) begin
         v = PAD_MARK;
      end else begin
         v = NOT_B64;
      end
      return v;
   endfunction

endpackage

>>> rtl/core/b64d_fifo.sv
// Small first-in first-out queue of fixed-width words.
// Depends on nothing; used for the command queue and the result queue.
module b64d_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/b64d_front.sv
// Front end of the decoder: classifies characters, builds groups of four
// and issues one command per character that releases results. Uses b64d_pkg.
module b64d_front
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   input  logic       end_of_input,
   output logic       cmd_push,
   output cmd_type    cmd
);

   logic [7:0]  partial_values_ff [3];
   logic [1:0]  partial_count_ff, partial_count_in;
   logic [23:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_pad_count_ff, held_pad_count_in;
   logic        held_present_ff, held_present_in;

   logic [7:0]  v;
   logic        valid;
   logic        release_held;
   logic        group_done;
   logic [7:0]  s3, s4;
   logic [1:0]  pads;
   logic [31:0] group_word;
   logic        held_mid;

   assign v            = char_value(char_code);
   assign valid        = (v != NOT_B64);
   assign release_held = valid && held_present_ff;
   assign group_done   = valid && (partial_count_ff == 2'd3);

   // Padding in the last two slots reads as zero; in the first two it keeps
   // its raw mark; its top bits spill into the previous slot or out of the word.
   always_comb begin
      s3   = partial_values_ff[2];
      s4   = v;
      pads = 2'd0;
      if (s3 == PAD_MARK) begin
         s3   = 8'd0;
         pads = pads + 2'd1;
      end
      if (s4 == PAD_MARK) begin
         s4   = 8'd0;
         pads = pads + 2'd1;
      end
      group_word = ({24'd0, partial_values_ff[0]} << 18) |
                   ({24'd0, partial_values_ff[1]} << 12) |
                   ({24'd0, s3} << 6) | {24'd0, s4};
   end

   always_comb begin
      partial_count_in  = partial_count_ff;
      held_bytes_in     = held_bytes_ff;
      held_pad_count_in = held_pad_count_ff;
      held_present_in   = held_present_ff;
      if (valid) begin
         held_present_in = 1'b0;
         if (group_done) begin
            held_bytes_in     = group_word[23:0];
            held_pad_count_in = pads;
            held_present_in   = 1'b1;
            partial_count_in  = 2'd0;
         end else begin
            partial_count_in = partial_count_ff + 2'd1;
         end
      end
      held_mid = held_present_in;

      cmd.data  = held_bytes_ff;
      cmd.count = 2'd0;
      cmd.tail  = TAIL_NONE;
      if (release_held) begin
         // A held group goes out whole; a message end here always leaves a
         // partial group behind, so it can only be the bad-count case.
         cmd.count = 2'd3;
         cmd.tail  = end_of_input ? TAIL_ERROR : TAIL_NONE;
      end else if (end_of_input) begin
         if (partial_count_in != 2'd0) begin
            cmd.tail = TAIL_ERROR;
         end else if (held_mid) begin
            cmd.data  = held_bytes_in;
            cmd.count = 2'd3 - held_pad_count_in;
            cmd.tail  = TAIL_EOM_LAST;
         end else begin
            cmd.tail = TAIL_EMPTY;
         end
      end
      cmd_push = accept && (release_held || end_of_input);

      if (end_of_input) begin
         partial_count_in  = 2'd0;
         held_pad_count_in = 2'd0;
         held_present_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_count_ff  <= 2'd0;
         held_pad_count_ff <= 2'd0;
         held_present_ff   <= 1'b0;
      end else if (accept) begin
         partial_count_ff  <= partial_count_in;
         held_pad_count_ff <= held_pad_count_in;
         held_present_ff   <= held_present_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_bytes_ff <= held_bytes_in;
         if (valid && !group_done) begin
            partial_values_ff[partial_count_ff] <= v;
         end
      end
   end

endmodule

>>> rtl/core/b64d_back.sv
// Back end of the decoder: takes commands and sends out one result word per
// cycle into the result queue while that queue has room. Uses b64d_pkg.
module b64d_back
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_word
);

   cmd_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [2:0] total;
   logic       last_word;
   logic       finishing;
   logic       extra;

   assign extra     = (cur_ff.tail == TAIL_ERROR) || (cur_ff.tail == TAIL_EMPTY);
   assign total     = {1'b0, cur_ff.count} + {2'b00, extra};
   assign last_word = ({1'b0, idx_ff} == total - 3'd1);
   assign out_push  = cur_valid_ff && !out_full;
   assign finishing = out_push && last_word;
   assign cmd_pop   = !cmd_empty && (!cur_valid_ff || finishing);

   always_comb begin
      out_word = '0;
      if (idx_ff < cur_ff.count) begin
         unique case (idx_ff)
            2'd0:    out_word.data_byte = cur_ff.data[23:16];
            2'd1:    out_word.data_byte = cur_ff.data[15:8];
            default: out_word.data_byte = cur_ff.data[7:0];
         endcase
         out_word.has_byte       = 1'b1;
         out_word.end_of_message = (cur_ff.tail == TAIL_EOM_LAST) && last_word;
      end else begin
         out_word.end_of_message = 1'b1;
         out_word.format_error   = (cur_ff.tail == TAIL_ERROR);
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (out_push) begin
         idx_in = idx_ff + 2'd1;
      end
      if (finishing) begin
         cur_valid_in = 1'b0;
      end
      if (cmd_pop) begin
         cur_in       = cmd;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> ({1'b0, idx_ff} < total))
      else $error("result index beyond the command's word count");

   a_no_byte_ends: assert property (@(posedge clock) disable iff (reset)
      out_push && !out_word.has_byte |-> out_word.end_of_message)
      else $error("word without a byte does not close the message");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      out_push && out_word.format_error |-> !out_word.has_byte && last_word)
      else $error("error word carries a byte or is not the last word");

   a_no_empty_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cmd.count != 2'd0) || (cmd.tail != TAIL_NONE))
      else $error("command without any result word");
`endif

endmodule

>>> rtl/core/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder.
// Instantiates b64d_front, b64d_back and two b64d_fifo queues; uses b64d_pkg.

// The decoder takes one character word per cycle through a push/full queue
// port and hands out result words through an empty/pop queue port. Characters
// outside A-Z, a-z, 0-9, '+', '/' and '=' are skipped; valid ones are grouped
// in fours and each group is held until the next valid character releases
// its three bytes, or until the message end releases them less one byte for
// each '=' in the last two slots. A message end always yields a word with
// end_of_message set: on the last byte, on an empty word for a message with
// no valid characters, or on an error word when the valid count is not a multiple
// of four (bytes already sent are not withdrawn). The front end classifies
// each character combinationally and so accepts a character every cycle
// while the command queue has room; the back end sends one result word per
// cycle while the result queue has room, and a character can give up to four
// words, so the command queue (CMD_DEPTH entries) absorbs such bursts.
// With ordinary text, which gives under one byte per character, req_full
// stays low. A result passes from the command queue through the back end's
// current-command register into the result queue; the result queue
// (OUT_DEPTH entries) lets the decoder keep going while a finished word waits
// to be popped.
module base64_stream_decoder_top
   import b64d_pkg::*;
#(
   parameter int CMD_DEPTH = CMD_DEPTH_DEF,
   parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_input,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_byte,
   output logic       rsp_end_of_message,
   output logic       rsp_format_error
);

   cmd_type cmd_in_word, cmd_out_word;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   rsp_type out_in_word, out_out_word;
   logic    out_push, out_full;
   logic    accept;

   // A character is taken whenever the command queue has room, even if this
   // character would give no command at all.
   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   b64d_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .cmd_push     (cmd_push),
      .cmd          (cmd_in_word)
   );

   b64d_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_word),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_word),
      .empty     (cmd_empty)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_out_word),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_word  (out_in_word)
   );

   b64d_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in_word),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_out_word),
      .empty     (rsp_empty)
   );

   assign rsp_data_byte      = out_out_word.data_byte;
   assign rsp_has_byte       = out_out_word.has_byte;
   assign rsp_end_of_message = out_out_word.end_of_message;
   assign rsp_format_error   = out_out_word.format_error;

endmodule

>>> bench/b64d_word_checker.sv
// Checker for the base64 stream decoder: watches both queue ports, predicts the
// result words of every accepted character and compares them as they are popped.
// Depends on b64d_pkg for the result word type and the character constants.
module b64d_word_checker
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_input,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_has_byte,
   input  logic       rsp_end_of_message,
   input  logic       rsp_format_error,
   output int         fail_count,
   output int         waiting_words
);

   rsp_type     expected_words[$];

   // Decoder state as the predictor sees it.
   logic [7:0]  slot_vals[3];
   logic [1:0]  slot_count;
   logic [23:0] held_word;
   logic [1:0]  held_pads;
   logic        held_valid;

   initial begin
      fail_count    = 0;
      waiting_words = 0;
   end

   function automatic logic [7:0] sextet_of(input logic [7:0] c);
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return c - CHAR_UC_A;
      if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return c - CHAR_LC_A + 8'd26;
      if (c >= CHAR_D0 && c <= CHAR_D9) return c - CHAR_D0 + 8'd52;
      if (c == CHAR_PLUS) return 8'd62;
      if (c == CHAR_SLASH) return 8'd63;
      if (c == CHAR_PAD) return PAD_MARK;
      return NOT_B64;
   endfunction

   function automatic void expect_word(input logic [7:0] b, input logic has,
                                       input logic eom, input logic err);
      rsp_type w;
      w.data_byte      = b;
      w.has_byte       = has;
      w.end_of_message = eom;
      w.format_error   = err;
      expected_words.push_back(w);
   endfunction

   task automatic decode_char(input logic [7:0] ch, input logic last);
      logic [7:0]  sv;
      logic [7:0]  s3;
      logic [7:0]  s4;
      logic [1:0]  pads;
      logic [31:0] w;
      logic [23:0] shifted;
      int          n;
      sv = sextet_of(ch);
      if (sv != NOT_B64) begin
         // Any valid character releases the whole held group.
         if (held_valid) begin
            expect_word(held_word[23:16], 1'b1, 1'b0, 1'b0);
            expect_word(held_word[15:8], 1'b1, 1'b0, 1'b0);
            expect_word(held_word[7:0], 1'b1, 1'b0, 1'b0);
            held_valid = 1'b0;
         end
         if (slot_count < 2'd3) begin
            slot_vals[slot_count] = sv;
            slot_count = slot_count + 2'd1;
         end else begin
            s3   = slot_vals[2];
            s4   = sv;
            pads = 2'd0;
            if (s3 == PAD_MARK) begin
               s3   = 8'd0;
               pads = pads + 2'd1;
            end
            if (s4 == PAD_MARK) begin
               s4   = 8'd0;
               pads = pads + 2'd1;
            end
            w = ({24'd0, slot_vals[0]} << 18) | ({24'd0, slot_vals[1]} << 12) |
                ({24'd0, s3} << 6) | {24'd0, s4};
            held_word  = w[23:0];
            held_pads  = pads;
            held_valid = 1'b1;
            slot_count = 2'd0;
         end
      end
      if (last) begin
         if (slot_count != 2'd0) begin
            expect_word(8'd0, 1'b0, 1'b1, 1'b1);
         end else if (held_valid) begin
            n = 3 - held_pads;
            for (int k = 0; k < n; k++) begin
               shifted = held_word >> (16 - 8 * k);
               expect_word(shifted[7:0], 1'b1, (k == n - 1), 1'b0);
            end
         end else begin
            expect_word(8'd0, 1'b0, 1'b1, 1'b0);
         end
         slot_count = 2'd0;
         held_pads  = 2'd0;
         held_valid = 1'b0;
      end
   endtask

   function automatic void compare_field(input string field, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_words.delete();
         slot_count = 2'd0;
         held_pads  = 2'd0;
         held_valid = 1'b0;
      end else begin
         if (req_push && !req_full) begin
            decode_char(req_char_code, req_end_of_input);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               $display("%0t: result word with none expected, actual byte %02h has %0b eom %0b err %0b",
                        $time, rsp_data_byte, rsp_has_byte, rsp_end_of_message,
                        rsp_format_error);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               compare_field("data_byte", want.data_byte, rsp_data_byte);
               compare_field("has_byte", want.has_byte, rsp_has_byte);
               compare_field("end_of_message", want.end_of_message, rsp_end_of_message);
               compare_field("format_error", want.format_error, rsp_format_error);
            end
         end
      end
      waiting_words = expected_words.size();
   end

endmodule

>>> bench/tb_top.sv
// Top of the base64 stream decoder testbench: clock, reset, character stimulus,
// result popping and the verdict. Depends on b64d_pkg, base64_stream_decoder_top
// and b64d_word_checker.
module tb_top;
   import b64d_pkg::*;

   // Generous bound on the whole run, well beyond the slowest correct one.
   localparam int CYCLE_LIMIT = 200000;
   // Length of the long stall on the result side.
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 390;

   logic       clock;
   logic       reset            = 1'b1;
   logic       req_push         = 1'b0;
   logic       req_full;
   logic [7:0] req_char_code    = 8'd0;
   logic       req_end_of_input = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop          = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_has_byte;
   logic       rsp_end_of_message;
   logic       rsp_format_error;

   int fail_count;
   int waiting_words;
   int cycle_count   = 0;
   int items_counted = 0;

   // While steady is set neither side idles; hold_request asks the receiver
   // for one long stall.
   bit steady       = 1'b0;
   bit hold_request = 1'b0;

   base64_stream_decoder_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_char_code      (req_char_code),
      .req_end_of_input   (req_end_of_input),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_format_error   (rsp_format_error)
   );

   b64d_word_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_char_code      (req_char_code),
      .req_end_of_input   (req_end_of_input),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_format_error   (rsp_format_error),
      .fail_count         (fail_count),
      .waiting_words      (waiting_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // True for the characters that the decoder does not skip.
   function automatic bit in_alphabet(input logic [7:0] c);
      return (c >= CHAR_UC_A && c <= CHAR_UC_Z) || (c >= CHAR_LC_A && c <= CHAR_LC_Z) ||
             (c >= CHAR_D0 && c <= CHAR_D9) || c == CHAR_PLUS || c == CHAR_SLASH ||
             c == CHAR_PAD;
   endfunction

   // Character that encodes a six-bit value.
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] x;
      x = {2'b00, v};
      if (x < 8'd26) return CHAR_UC_A + x;
      if (x < 8'd52) return CHAR_LC_A + x - 8'd26;
      if (x < 8'd62) return CHAR_D0 + x - 8'd52;
      if (x == 8'd62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // Any byte that the decoder skips.
   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (in_alphabet(c)) c = 8'($urandom_range(255));
      return c;
   endfunction

   // Offers one character word and returns at the edge that accepts it. The
   // valid is only lowered for an idle cycle, so it never drops and rises
   // again within one time step.
   task automatic send_word(input logic [7:0] ch, input logic last);
      while (!steady && $urandom_range(99) < 38) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_char_code    <= ch;
      req_end_of_input <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_counted++;
   endtask

   task automatic send_text(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) begin
         send_word(s[i], end_last && (i == s.len() - 1));
      end
   endtask

   // A properly padded message of nbytes random bytes, with the odd skipped
   // character mixed in. Sometimes the end flag rides on a trailing skipped
   // character instead of the last valid one.
   task automatic send_encoded(input int nbytes);
      logic [7:0]  text[$];
      logic [23:0] grp;
      int          left;
      bit          tail_noise;
      left = nbytes;
      while (left > 0) begin
         grp = 24'($urandom());
         text.push_back(sextet_char(grp[23:18]));
         text.push_back(sextet_char(grp[17:12]));
         text.push_back(left > 1 ? sextet_char(grp[11:6]) : CHAR_PAD);
         text.push_back(left > 2 ? sextet_char(grp[5:0]) : CHAR_PAD);
         left -= 3;
      end
      tail_noise = (text.size() == 0) || ($urandom_range(4) == 0);
      for (int i = 0; i < text.size(); i++) begin
         if ($urandom_range(9) == 0) send_word(noise_char(), 1'b0);
         send_word(text[i], !tail_noise && (i == text.size() - 1));
      end
      if (tail_noise) send_word(noise_char(), 1'b1);
   endtask

   // Receiver: pops at random, except for one long stall on request, which it
   // counts out itself while the sender keeps offering characters.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_pop <= steady || ($urandom_range(99) >= 38);
      end
   end

   // Watchdog: a run that has not finished by the limit has hung.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top failed");
      $finish;
   end

   initial begin
      int target;
      int kind;
      int len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first message has two full groups, so the first
      // group is released by a valid character and the second by the end,
      // covering both ends of every character range along the way.
      send_text("AZaz/09+", 1'b1);
      // A skipped character without the end flag changes nothing.
      send_word(8'hFF, 1'b0);
      // Two pads in the last slots leave a single byte.
      send_text("QQ==", 1'b1);
      // Padding in the first slot takes the pad mark as its value.
      send_text("=B==", 1'b1);
      // A bad count after a released group: three bytes, then the error word.
      send_text("ABCDE", 1'b1);
      // A message with no valid characters at all.
      send_word(8'h00, 1'b1);

      // Fill the decoder while the receiver stalls, so that req_full rises.
      hold_request = 1'b1;
      for (int i = 0; i < 16; i++) send_text("TWFu", 1'b0);
      send_text("TWFu", 1'b1);

      // Random part: mostly well-formed messages, some with a broken count or
      // stray padding, and some raw bytes. One stretch runs with no idling.
      target = items_counted + RANDOM_ITEMS;
      while (items_counted < target) begin
         steady = (items_counted >= target - RANDOM_ITEMS + 200) &&
                  (items_counted < target - RANDOM_ITEMS + 290);
         kind = $urandom_range(99);
         if (kind < 65) begin
            send_encoded($urandom_range(9));
         end else if (kind < 85) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               send_word(($urandom_range(99) < 15) ? CHAR_PAD :
                         sextet_char(6'($urandom_range(63))), i == len - 1);
            end
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               send_word(8'($urandom_range(255)), (i == len - 1) && $urandom_range(1));
            end
         end
      end
      steady = 1'b0;
      req_push <= 1'b0;

      // Let every expected word arrive, then allow for the pipeline latency
      // so that any stray word still shows up. The count is read at the following
      // edge so that it already includes the last character's words.
      @(posedge clock);
      while (waiting_words != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0 && waiting_words == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
